FILE: rtl/lssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lssd_pkg
// Shared types, constants and the color scaling function of the LED strip
// serial driver.
// ---------------------------------------------------------------------------
package lssd_pkg;

	// Default strip length held in the pixel store
	localparam int unsigned LSSD_MAX_LEDS_DEF = 512;

	// Pixel word layout: marker, green, red, blue (5 bits each)
	localparam logic [15:0] LSSD_MARKER = 16'h8000;

	// Frame layout in bits
	localparam logic [5:0] LSSD_HEADER_BITS = 6'd32;
	localparam logic [3:0] LSSD_WORD_LAST   = 4'd15;

	// Action codes carried on tuser
	localparam logic [1:0] ACT_PIXEL_WRITE = 2'd0;
	localparam logic [1:0] ACT_SHOW        = 2'd1;
	localparam logic [1:0] ACT_TICK        = 2'd2;

	// One request to the single-port pixel store
	typedef struct packed {
		logic        wr_en;
		logic        rd_en;
		logic [9:0]  addr;
		logic [15:0] wr_data;
	} lssd_mem_req_t;

	// Result fields that wait in the read stage for the pixel store read
	typedef struct packed {
		logic       from_mem;
		logic [3:0] bit_sel;
		logic       clock_pulse;
		logic       busy;
		logic       accepted;
	} lssd_res_t;

	// floor(v * 31 / 255) without a divider
	function automatic logic [4:0] lssd_scale5(input logic [7:0] v);
		logic [13:0] x;
		logic [13:0] q;
		x = {1'b0, v, 5'b00000} - {6'b000000, v};
		q = (x + {8'h00, x[13:8]} + 14'd1) >> 8;
		return q[4:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/led_strip_serial_driver.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_strip_serial_driver
// Serializer for a strip of 15-bit RGB LEDs with an on-chip pixel store.
//
// Input stream: tuser carries the action (pixel write, show, bit tick),
// tdata the pixel index, color levels and LED count. Each input transfer
// gives exactly one output transfer holding data_bit, clock_pulse,
// busy_res and accepted. A frame is 32 zero header bits followed by
// 16 bits per LED, most significant bit first, one bit per tick.
// One item is taken every cycle unless the output stalls, since each
// item needs at most one access to the single-port pixel store and its
// read data is used in the next stage. After reset the store is swept
// to the marker word, one entry per cycle, so s_tready stays low until
// the sweep is done. When the receiver stalls, the output register
// holds its result and the input side keeps taking items until the
// one-entry read stage is also full.
// ---------------------------------------------------------------------------
module led_strip_serial_driver #(
	parameter int unsigned MAX_LEDS = lssd_pkg::LSSD_MAX_LEDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue,
	// [43:34] led_count, [47:44] zero
	input  wire  [47:0] s_tdata,
	// [1:0] action
	input  wire  [1:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] data_bit, [1] clock_pulse, [2] busy_res, [3] accepted, [7:4] zero
	output logic [7:0]  m_tdata
);
	import lssd_pkg::*;

	lssd_mem_req_t mem_req;
	lssd_res_t     res;
	lssd_res_t     res_s1;
	logic [15:0]   rd_data;
	logic          init_done;
	logic          fire;
	logic          valid_s1;
	logic          adv_s1;
	logic          valid_s2;
	logic [3:0]    out_s2;
	logic          bit_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = init_done && (!valid_s1 || adv_s1);
	assign fire     = s_tvalid && s_tready;

	lssd_frame_seq #(
		.MAX_LEDS(MAX_LEDS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.action     (s_tuser),
		.pixel_index(s_tdata[9:0]),
		.red        (s_tdata[17:10]),
		.green      (s_tdata[25:18]),
		.blue       (s_tdata[33:26]),
		.led_count  (s_tdata[43:34]),
		.mem_req    (mem_req),
		.res        (res)
	);

	lssd_pixel_mem #(
		.MAX_LEDS(MAX_LEDS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_data  (rd_data),
		.init_done(init_done)
	);

	// Pick the frame bit out of the word just read
	assign bit_s1 = res_s1.from_mem && rd_data[res_s1.bit_sel];

	// Read stage: wait for the store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2 <= {res_s1.accepted, res_s1.busy, res_s1.clock_pulse, bit_s1};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, out_s2};

endmodule
`default_nettype wire

FILE: rtl/lssd_pixel_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lssd_pixel_mem
// Single-port pixel store with registered read data and a clearing pass
// that fills every entry with the marker word after reset.
// ---------------------------------------------------------------------------
module lssd_pixel_mem #(
	parameter int unsigned MAX_LEDS = lssd_pkg::LSSD_MAX_LEDS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  lssd_pkg::lssd_mem_req_t req,
	output logic [15:0]            rd_data,
	output logic                   init_done
);
	import lssd_pkg::*;

	localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

	logic [15:0]   mem [MAX_LEDS];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [15:0]   wd;

	// Sweep the store once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign init_done = !clearing_q;

	// Clearing pass owns the write port until done
	always_comb begin
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = LSSD_MARKER;
		end else begin
			we = req.wr_en;
			wa = req.addr[AW-1:0];
			wd = req.wr_data;
		end
	end

	// Storage array, read data held until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.addr[AW-1:0]];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lssd_frame_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lssd_frame_seq
// Frame sequencer: decodes each action, keeps the frame position and
// issues pixel store writes and reads.
// ---------------------------------------------------------------------------
module lssd_frame_seq #(
	parameter int unsigned MAX_LEDS = lssd_pkg::LSSD_MAX_LEDS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     fire,
	input  wire  [1:0]              action,
	input  wire  [9:0]              pixel_index,
	input  wire  [7:0]              red,
	input  wire  [7:0]              green,
	input  wire  [7:0]              blue,
	input  wire  [9:0]              led_count,
	output lssd_pkg::lssd_mem_req_t mem_req,
	output lssd_pkg::lssd_res_t     res
);
	import lssd_pkg::*;

	localparam logic [9:0] MAX_CNT = 10'(MAX_LEDS);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [5:0] bit_cnt_q, bit_cnt_d;
	logic [9:0] led_pos_q, led_pos_d;
	logic [9:0] frame_len_q, frame_len_d;
	logic [9:0] pos_inc;
	logic       busy_now;

	assign pos_inc  = led_pos_q + 10'd1;
	assign busy_now = (phase_q == PH_HEADER) || (phase_q == PH_DATA);

	// Decode the action and step the frame
	always_comb begin
		phase_d         = phase_q;
		bit_cnt_d       = bit_cnt_q;
		led_pos_d       = led_pos_q;
		frame_len_d     = frame_len_q;
		mem_req.wr_en   = 1'b0;
		mem_req.rd_en   = 1'b0;
		mem_req.addr    = led_pos_q;
		mem_req.wr_data = {LSSD_MARKER[15], lssd_scale5(green), lssd_scale5(red),
			lssd_scale5(blue)};
		res             = '0;
		res.bit_sel     = ~bit_cnt_q[3:0];
		case (action)
			ACT_PIXEL_WRITE: begin
				mem_req.addr = pixel_index;
				if (pixel_index < MAX_CNT) begin
					mem_req.wr_en = fire;
					res.accepted  = 1'b1;
				end
				res.busy = busy_now;
			end
			ACT_SHOW: begin
				res.busy = 1'b1;
				if (!busy_now) begin
					res.accepted = 1'b1;
					frame_len_d  = (led_count > MAX_CNT) ? MAX_CNT : led_count;
					phase_d      = PH_HEADER;
					bit_cnt_d    = '0;
					led_pos_d    = '0;
				end
			end
			ACT_TICK: begin
				res.clock_pulse = 1'b1;
				res.accepted    = 1'b1;
				case (phase_q)
					PH_HEADER: begin
						res.busy  = 1'b1;
						bit_cnt_d = bit_cnt_q + 6'd1;
						if (bit_cnt_q == LSSD_HEADER_BITS - 6'd1) begin
							bit_cnt_d = '0;
							led_pos_d = '0;
							phase_d   = (frame_len_q == '0) ? PH_IDLE : PH_DATA;
						end
					end
					PH_DATA: begin
						res.busy      = 1'b1;
						res.from_mem  = (led_pos_q < MAX_CNT);
						mem_req.rd_en = fire;
						bit_cnt_d     = bit_cnt_q + 6'd1;
						if (bit_cnt_q[3:0] == LSSD_WORD_LAST) begin
							bit_cnt_d = '0;
							led_pos_d = pos_inc;
							if (pos_inc >= frame_len_q) begin
								phase_d   = PH_IDLE;
								led_pos_d = '0;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Hold frame state, advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= '0;
			led_pos_q   <= '0;
			frame_len_q <= MAX_CNT;
		end else if (fire) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			led_pos_q   <= led_pos_d;
			frame_len_q <= frame_len_d;
		end
	end

endmodule
`default_nettype wire
